// ===== rtl/rkx_pkg.sv =====
// ----------------------------------------------------------------------------
// rkx_pkg
// Shared types and character codes for the RESP command key extractor.
// ----------------------------------------------------------------------------
package rkx_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_KEY_BYTE  = 2'd0,
    ST_EMPTY_KEY = 2'd1,
    ST_NO_KEY    = 2'd2
  } status_t;

  // Protocol characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // One result item
  typedef struct packed {
    logic [7:0] key_byte;
    status_t    status;
    logic       key_last;
  } result_t;

endpackage

// ===== rtl/rkx_if.sv =====
// ----------------------------------------------------------------------------
// rkx_in_if / rkx_out_if
// Valid/ready channels for request bytes in and key results out.
// ----------------------------------------------------------------------------
interface rkx_in_if import rkx_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface rkx_out_if import rkx_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  status_t    status;
  logic       key_last;

  modport source (output valid, output key_byte, output status, output key_last,
                  input ready);
  modport sink   (input valid, input key_byte, input status, input key_last,
                  output ready);
endinterface

// ===== rtl/resp_command_key_extractor.sv =====
// ----------------------------------------------------------------------------
// resp_command_key_extractor
// Parses a RESP request one byte per transfer and returns the bytes of the
// key, the second bulk string of the top-level array.
// ----------------------------------------------------------------------------
// A result is registered into the output register on its input transfer, or
// into the skid register if the output is stalled. Throughput: one byte per
// cycle while input ready is high. An output register plus a skid register
// absorb a stalled output; input ready drops only when both hold a result.
// Reset (synchronous, rst_n low): parser expects '*', counters clear, both
// output stages empty.
module resp_command_key_extractor import rkx_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  rkx_in_if.sink   in_ch,
  rkx_out_if.source out_ch
);

  typedef enum logic [3:0] {
    PH_STAR, PH_CNT0, PH_CNT, PH_CNT_LF, PH_DOLLAR, PH_LEN0, PH_LEN,
    PH_LEN_LF, PH_DATA, PH_TRAIL1, PH_TRAIL2, PH_IDLE
  } phase_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  phase_t                   phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0]   elems_r, elems_nxt;
  logic                     elem_num_r, elem_num_nxt;
  logic [COUNT_WIDTH-1:0]   num_r, num_nxt;
  logic                     msg_done_r, msg_done_nxt;

  logic                     in_xfer;
  logic                     out_take;
  logic                     is_digit;
  logic [COUNT_WIDTH+3:0]   num_wide;
  logic [COUNT_WIDTH-1:0]   num_acc;
  logic [COUNT_WIDTH-1:0]   num_dec;
  logic                     emit;
  result_t                  res;

  logic                     out_valid_r;
  result_t                  out_r;
  logic                     skid_valid_r;
  result_t                  skid_r;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;
  assign in_ch.ready = !skid_valid_r;

  // Accumulate one decimal digit, saturating at all ones
  assign is_digit = (in_ch.data_byte >= CH_ZERO) && (in_ch.data_byte <= CH_NINE);
  assign num_wide = ({4'd0, num_r} << 3) + ({4'd0, num_r} << 1)
                  + {{COUNT_WIDTH{1'b0}}, in_ch.data_byte[3:0]};
  assign num_acc  = (num_wide[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0) ? COUNT_MAX
                  : num_wide[COUNT_WIDTH-1:0];
  assign num_dec  = num_r - COUNT_WIDTH'(1);

  // Parser next state and result
  always_comb begin
    phase_nxt    = phase_r;
    elems_nxt    = elems_r;
    elem_num_nxt = elem_num_r;
    num_nxt      = num_r;
    msg_done_nxt = msg_done_r;
    emit         = 1'b0;
    res.key_byte = 8'd0;
    res.status   = ST_KEY_BYTE;
    res.key_last = 1'b0;

    unique case (phase_r)
      PH_STAR: begin
        phase_nxt = (in_ch.data_byte == CH_STAR) ? PH_CNT0 : PH_IDLE;
        num_nxt   = '0;
      end
      PH_CNT0, PH_CNT: begin
        if (is_digit) begin
          num_nxt   = num_acc;
          phase_nxt = PH_CNT;
        end else if (in_ch.data_byte == CH_CR && phase_r == PH_CNT) begin
          phase_nxt = PH_CNT_LF;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_CNT_LF: begin
        if (in_ch.data_byte == CH_LF) begin
          elems_nxt    = num_r;
          num_nxt      = '0;
          elem_num_nxt = 1'b0;
          phase_nxt    = PH_DOLLAR;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DOLLAR: begin
        if (elems_r == '0 || in_ch.data_byte != CH_DOLLAR) begin
          phase_nxt = PH_IDLE;
        end else begin
          elems_nxt = elems_r - COUNT_WIDTH'(1);
          num_nxt   = '0;
          phase_nxt = PH_LEN0;
        end
      end
      PH_LEN0, PH_LEN: begin
        if (is_digit) begin
          num_nxt   = num_acc;
          phase_nxt = PH_LEN;
        end else if (in_ch.data_byte == CH_CR && phase_r == PH_LEN) begin
          phase_nxt = PH_LEN_LF;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_LEN_LF: begin
        if (in_ch.data_byte != CH_LF) begin
          phase_nxt = PH_IDLE;
        end else if (num_r != '0) begin
          phase_nxt = PH_DATA;
        end else if (elem_num_r) begin
          // Empty key
          emit         = 1'b1;
          res.status   = ST_EMPTY_KEY;
          res.key_last = 1'b1;
          msg_done_nxt = 1'b1;
          phase_nxt    = PH_IDLE;
        end else begin
          phase_nxt = PH_TRAIL1;
        end
      end
      PH_DATA: begin
        num_nxt = num_dec;
        if (elem_num_r) begin
          emit         = 1'b1;
          res.key_byte = in_ch.data_byte;
          if (num_dec == '0 || in_ch.end_of_buffer) begin
            res.key_last = 1'b1;
            msg_done_nxt = 1'b1;
            phase_nxt    = PH_IDLE;
          end
        end else if (num_dec == '0) begin
          phase_nxt = PH_TRAIL1;
        end
      end
      PH_TRAIL1: phase_nxt = PH_TRAIL2;
      PH_TRAIL2: begin
        elem_num_nxt = 1'b1;
        phase_nxt    = PH_DOLLAR;
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // End of buffer: close the message and re-arm
    if (in_ch.end_of_buffer) begin
      if (!emit && !msg_done_r) begin
        emit         = 1'b1;
        res.key_byte = 8'd0;
        res.status   = ST_NO_KEY;
        res.key_last = 1'b1;
      end
      phase_nxt    = PH_STAR;
      elems_nxt    = '0;
      elem_num_nxt = 1'b0;
      num_nxt      = '0;
      msg_done_nxt = 1'b0;
    end
  end

  // Advance parser state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_STAR;
      elems_r    <= '0;
      elem_num_r <= 1'b0;
      num_r      <= '0;
      msg_done_r <= 1'b0;
    end else if (in_xfer) begin
      phase_r    <= phase_nxt;
      elems_r    <= elems_nxt;
      elem_num_r <= elem_num_nxt;
      num_r      <= num_nxt;
      msg_done_r <= msg_done_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= in_xfer && emit;
      out_r       <= res;
    end else if (in_xfer && emit) begin
      skid_valid_r <= 1'b1;
      skid_r       <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_byte = out_r.key_byte;
  assign out_ch.status   = out_r.status;
  assign out_ch.key_last = out_r.key_last;

endmodule

// ===== rtl/rkx_checker.sv =====
// ----------------------------------------------------------------------------
// rkx_checker
// Port-level checks on the key extractor's result channel.
// ----------------------------------------------------------------------------
module rkx_checker import rkx_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_key_byte,
  input status_t    out_status,
  input logic       out_key_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_byte)
      && $stable(out_status) && $stable(out_key_last))
    else $error("result changed while stalled");

  // Status-only results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_KEY_BYTE |-> out_key_byte == 8'd0)
    else $error("status result with nonzero key byte");

  // Status-only results always close the message
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_KEY_BYTE |-> out_key_last)
    else $error("status result without key_last");

  // Drop any result across reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind resp_command_key_extractor rkx_checker u_rkx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_key_byte (out_ch.key_byte),
  .out_status   (out_ch.status),
  .out_key_last (out_ch.key_last)
);

// ===== sim/resp_command_key_extractor_test.sv =====
// ----------------------------------------------------------------------------
// resp_command_key_extractor_test
// Drives RESP request buffers into the key extractor one byte per transfer
// and checks every key result against a cycle-free parser model kept in the
// bench. It covers well-formed, empty-key, malformed, truncated and saturating
// requests, then runs random requests under three idle profiles and one long
// output stall.
// ----------------------------------------------------------------------------
module resp_command_key_extractor_test;
  import rkx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CW          = 32;
  localparam logic [63:0] COUNT_MAX   = {64{1'b1}} >> (64 - CW);
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_WAIT  = 10;

  typedef enum logic [3:0] {
    P_STAR, P_CNT0, P_CNT, P_CNT_LF, P_DOLLAR, P_LEN0, P_LEN, P_LEN_LF,
    P_DATA, P_TRAIL1, P_TRAIL2, P_IDLE
  } parse_state_t;

  logic clk;
  logic rst_n;

  rkx_in_if  in_ch ();
  rkx_out_if out_ch ();

  resp_command_key_extractor #(.COUNT_WIDTH(CW)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Parser model state
  parse_state_t parse_state;
  logic [63:0]  elems_left;
  logic         elem_idx;
  logic [63:0]  num_acc;
  logic         key_done;

  result_t      key_results_q[$];
  logic [7:0]   msg_bytes[$];

  int errors;
  int cycle_count;
  int bytes_sent;
  int buffers_sent;
  int key_bytes_seen;
  int empty_keys_seen;
  int no_keys_seen;
  int src_idle_pct;
  int sink_idle_pct;
  int rx_hold_req;
  int rx_hold_left;

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               key_results_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic void clear_parser();
    parse_state = P_STAR;
    elems_left  = '0;
    elem_idx    = 1'b0;
    num_acc     = '0;
    key_done    = 1'b0;
  endfunction

  // Decimal accumulate with saturation at the counter width
  function automatic logic [63:0] add_digit(logic [63:0] acc, logic [7:0] ch);
    logic [63:0] d;
    d = 64'(ch - CH_ZERO);
    if (acc > (COUNT_MAX - d) / 10) return COUNT_MAX;
    return acc * 10 + d;
  endfunction

  // Advance the model by one byte; return 1 when the byte yields a result
  function automatic bit extract_key_byte(logic [7:0] b, logic eob, output result_t r);
    bit         emit;
    bit         digit;
    logic [7:0] kb;
    status_t    st;
    logic       last;
    emit  = 1'b0;
    kb    = 8'h00;
    st    = ST_KEY_BYTE;
    last  = 1'b0;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    case (parse_state)
      P_STAR: begin
        parse_state = (b == CH_STAR) ? P_CNT0 : P_IDLE;
        num_acc     = '0;
      end
      P_CNT0, P_CNT: begin
        if (digit) begin
          num_acc     = add_digit(num_acc, b);
          parse_state = P_CNT;
        end else if (b == CH_CR && parse_state == P_CNT) begin
          parse_state = P_CNT_LF;
        end else begin
          parse_state = P_IDLE;
        end
      end
      P_CNT_LF: begin
        if (b == CH_LF) begin
          elems_left  = num_acc;
          num_acc     = '0;
          elem_idx    = 1'b0;
          parse_state = P_DOLLAR;
        end else begin
          parse_state = P_IDLE;
        end
      end
      P_DOLLAR: begin
        if (elems_left == 0 || b != CH_DOLLAR) begin
          parse_state = P_IDLE;
        end else begin
          elems_left--;
          num_acc     = '0;
          parse_state = P_LEN0;
        end
      end
      P_LEN0, P_LEN: begin
        if (digit) begin
          num_acc     = add_digit(num_acc, b);
          parse_state = P_LEN;
        end else if (b == CH_CR && parse_state == P_LEN) begin
          parse_state = P_LEN_LF;
        end else begin
          parse_state = P_IDLE;
        end
      end
      P_LEN_LF: begin
        if (b != CH_LF) begin
          parse_state = P_IDLE;
        end else if (num_acc != 0) begin
          parse_state = P_DATA;
        end else if (elem_idx) begin
          emit        = 1'b1;
          st          = ST_EMPTY_KEY;
          last        = 1'b1;
          key_done    = 1'b1;
          parse_state = P_IDLE;
        end else begin
          parse_state = P_TRAIL1;
        end
      end
      P_DATA: begin
        num_acc--;
        if (elem_idx) begin
          emit = 1'b1;
          kb   = b;
          if (num_acc == 0 || eob) begin
            last        = 1'b1;
            key_done    = 1'b1;
            parse_state = P_IDLE;
          end
        end else if (num_acc == 0) begin
          parse_state = P_TRAIL1;
        end
      end
      P_TRAIL1: parse_state = P_TRAIL2;
      P_TRAIL2: begin
        elem_idx    = 1'b1;
        parse_state = P_DOLLAR;
      end
      default: parse_state = P_IDLE;
    endcase
    // End of buffer: close out the message and re-arm
    if (eob) begin
      if (!emit && !key_done) begin
        emit = 1'b1;
        kb   = 8'h00;
        st   = ST_NO_KEY;
        last = 1'b1;
      end
      clear_parser();
    end
    r.key_byte = kb;
    r.status   = st;
    r.key_last = last;
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      case (out_ch.status)
        ST_KEY_BYTE:  key_bytes_seen++;
        ST_EMPTY_KEY: empty_keys_seen++;
        default:      no_keys_seen++;
      endcase
      if (key_results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result key_byte=%02h status=%0d key_last=%0b", $time,
                 out_ch.key_byte, out_ch.status, out_ch.key_last);
      end else begin
        exp_r = key_results_q.pop_front();
        if (out_ch.key_byte !== exp_r.key_byte) begin
          errors++;
          $display("%0t: key_byte expected %02h actual %02h", $time, exp_r.key_byte,
                   out_ch.key_byte);
        end
        if (out_ch.status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_ch.status);
        end
        if (out_ch.key_last !== exp_r.key_last) begin
          errors++;
          $display("%0t: key_last expected %0b actual %0b", $time, exp_r.key_last,
                   out_ch.key_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request building and sending
  // ---------------------------------------------------------------------------
  // Append one byte to the request under construction
  function automatic void append_msg_byte(logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  // Queue one expected result behind the earlier ones
  function automatic void append_expected(result_t r);
    key_results_q.insert(key_results_q.size(), r);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) append_msg_byte(s[i]);
  endfunction

  function automatic void add_num(int v);
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_random_bytes(int n);
    repeat (n) append_msg_byte(8'($urandom_range(255)));
  endfunction

  // Offer one byte, hold it until the transfer, then predict its result
  task automatic send_byte(logic [7:0] b, logic eob);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.data_byte     = b;
    in_ch.end_of_buffer = eob;
    do @(posedge clk); while (!in_ch.ready);
    if (extract_key_byte(b, eob, r)) append_expected(r);
    bytes_sent++;
  endtask

  // Send the built buffer up to last_idx, marking that byte as end of buffer
  task automatic send_buffer(int last_idx);
    for (int i = 0; i <= last_idx; i++) send_byte(msg_bytes[i], i == last_idx);
    msg_bytes.delete();
    buffers_sent++;
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_buffer(msg_bytes.size() - 1);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Random request: mostly well-formed with random content, some noise/damage
  function automatic void build_request();
    int pick;
    int sel;
    int n_elems;
    int len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      add_random_bytes($urandom_range(1, 6));
      return;
    end
    sel = $urandom_range(19);
    add_text("*");
    if ($urandom_range(9) == 0) add_text("0");
    if (sel == 0) begin
      add_text("0");
      n_elems = 1;
    end else if (sel == 1) begin
      add_text("99999999999");
      n_elems = 3;
    end else begin
      n_elems = $urandom_range(1, 4);
      add_num(n_elems);
      if (n_elems > 3) n_elems = 3;
    end
    add_text("\r\n");
    for (int i = 0; i < n_elems; i++) begin
      add_text("$");
      if (i == 1 && $urandom_range(9) == 0) len = $urandom_range(9, 40);
      else len = $urandom_range(0, 6);
      add_num(len);
      add_text("\r\n");
      add_random_bytes(len);
      if ($urandom_range(3) == 0) add_random_bytes(2);
      else add_text("\r\n");
    end
    add_random_bytes($urandom_range(0, 3));
    if (pick < 20) msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_well_formed();
    send_text("*2\r\n$3\r\nGET\r\n$1\r\nk\r\n");
    send_text("*3\r\n$3\r\nSET\r\n$2\r\nab\r\n$1\r\nv\r\n");
    // Key with extreme byte values, leading-zero length
    add_text("*02\r\n$1\r\nG\r\n$03\r\n");
    append_msg_byte(8'h00);
    append_msg_byte(8'hFF);
    append_msg_byte(CH_CR);
    add_text("\r\n");
    send_buffer(msg_bytes.size() - 1);
  endtask

  task automatic test_empty_key();
    send_text("*2\r\n$1\r\nX\r\n$0\r\n\r\n");
    send_text("*2\r\n$0\r\n\r\n$1\r\nq\r\n");
  endtask

  task automatic test_malformed();
    send_text("A");
    send_text("*\r\n");
    send_text("*1x");
    send_text("*2\r\n#");
    send_text("*2\r\n$-1\r\n");
    send_text("*2\rX");
    send_text("*2\r\n$1\r\nG\r\n$1\rX");
    send_text("*0\r\n$1");
    send_text("*1\r\n$1\r\nG\r\n$");
  endtask

  task automatic test_truncated();
    send_text("*");
    send_text("*2\r\n$1\r\nG\r\n$5\r\nab");
    send_text("*2\r\n$1\r\nG\r\n$5\r");
    send_text("*2\r\n$1\r\nG\r\n$1\r\nk\r\nJUNK");
  endtask

  task automatic test_saturation();
    send_text("*99999999999\r\n$1\r\nG\r\n$1\r\nk\r\n");
    send_text("*2\r\n$1\r\nG\r\n$4294967295\r\nxyz");
    send_text("*2\r\n$1\r\nG\r\n$18446744073709551616\r\nab");
  endtask

  task automatic test_random(int src_pct, int sink_pct, int n_bytes);
    int start_bytes;
    int last_idx;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    start_bytes   = bytes_sent;
    while (bytes_sent - start_bytes < n_bytes) begin
      build_request();
      if ($urandom_range(9) < 2) last_idx = $urandom_range(0, msg_bytes.size() - 1);
      else last_idx = msg_bytes.size() - 1;
      send_buffer(last_idx);
    end
  endtask

  // Hold the output off for a long stretch while a long key streams in
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    drop_valid();
    @(posedge clk);
    rx_hold_req = 300;
    add_text("*2\r\n$1\r\nG\r\n$60\r\n");
    add_random_bytes(60);
    add_text("\r\n");
    send_buffer(msg_bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready        = 1'b0;
    rst_n               = 1'b0;
    errors              = 0;
    cycle_count         = 0;
    bytes_sent          = 0;
    buffers_sent        = 0;
    key_bytes_seen      = 0;
    empty_keys_seen     = 0;
    no_keys_seen        = 0;
    rx_hold_req         = 0;
    rx_hold_left        = 0;
    src_idle_pct        = 11;
    sink_idle_pct       = 51;
    clear_parser();

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_well_formed();
    test_empty_key();
    test_malformed();
    test_truncated();
    test_saturation();
    test_random(11, 51, 130);
    test_random(51, 11, 130);
    test_random(0, 0, 130);
    test_backpressure();
    test_random(0, 0, 20);

    // Drain outstanding results
    drop_valid();
    while (key_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers over three idle profiles and one long stall.",
             bytes_sent, buffers_sent);
    $display("Checked %0d key bytes, %0d empty keys, %0d no-key results.",
             key_bytes_seen, empty_keys_seen, no_keys_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rkx_pkg.sv
rtl/rkx_if.sv
rtl/resp_command_key_extractor.sv
rtl/rkx_checker.sv
sim/resp_command_key_extractor_test.sv
